FILE: hdl/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants for the Taylor sine evaluator: the lane word
// that flows from cell to cell and the Horner coefficient table.
// ----------------------------------------------------------------------------
package tse_pkg;

   // Port widths of the angle and the result
   localparam int unsigned ANGLE_W   = 31;
   localparam int unsigned SINE_W    = 30;

   // Internal working format: Q60 for x^2, coefficients and the accumulator
   localparam int unsigned WORK_FRAC = 60;
   localparam int unsigned WORD_W    = 64;

   // One lane word: what every cell hands to its neighbour
   typedef struct packed {
      logic                     valid;
      logic                     xneg;
      logic [ANGLE_W-1:0]       ax;
      logic [WORD_W-1:0]        x2;
      logic signed [WORD_W-1:0] s;
   } lane_type;

   // Coefficients floor(2^60/(2n+1)!), built by repeated truncating division
   function automatic logic [WORD_W-1:0] coef(input int unsigned idx);
      logic [WORD_W-1:0] c;
      case (idx)
         0:       c = 64'd1152921504606846976;
         1:       c = 64'd192153584101141162;
         2:       c = 64'd9607679205057058;
         3:       c = 64'd228754266787072;
         4:       c = 64'd3177142594264;
         5:       c = 64'd28883114493;
         6:       c = 64'd185148169;
         7:       c = 64'd881657;
         8:       c = 64'd3241;
         9:       c = 64'd9;
         default: c = 64'd0;
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/tse_front.sv
// ----------------------------------------------------------------------------
// tse_front
// Entry of the chain: takes the magnitude of the angle, clamps it to 3.2,
// squares it into Q60 and seeds the accumulator with the last coefficient.
// ----------------------------------------------------------------------------
module tse_front #(
   parameter int unsigned       FRAC_BITS = 28,
   parameter logic [63:0]       START     = 64'd0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                req_valid,
   input  logic signed [tse_pkg::ANGLE_W-1:0]  req_angle,
   output tse_pkg::lane_type                   lane_out
);

   localparam logic [63:0] LIMIT    = (64'd16 << FRAC_BITS) / 64'd5;
   localparam int unsigned SQ_SHIFT = tse_pkg::WORK_FRAC - 2 * FRAC_BITS;

   logic                           valid_a_ff, valid_a_in;
   logic                           xneg_a_ff, xneg_a_in;
   logic [tse_pkg::ANGLE_W-1:0]    ax_a_ff, ax_a_in;
   logic [tse_pkg::ANGLE_W-1:0]    ax_abs;
   logic [2*tse_pkg::ANGLE_W-1:0]  sq;
   tse_pkg::lane_type              lane_ff, lane_in;

   // Take the magnitude and clamp it to the angle limit
   always_comb begin
      valid_a_in = req_valid;
      xneg_a_in  = req_angle[tse_pkg::ANGLE_W-1];
      ax_abs     = xneg_a_in ? (tse_pkg::ANGLE_W'(0) - $unsigned(req_angle))
                             : $unsigned(req_angle);
      if ({33'd0, ax_abs} > LIMIT) begin
         ax_a_in = LIMIT[tse_pkg::ANGLE_W-1:0];
      end else begin
         ax_a_in = ax_abs;
      end
   end

   // Square into Q60 and seed the accumulator
   always_comb begin
      sq              = (2*tse_pkg::ANGLE_W)'(ax_a_ff) * (2*tse_pkg::ANGLE_W)'(ax_a_ff);
      lane_in.valid   = valid_a_ff;
      lane_in.xneg    = xneg_a_ff;
      lane_in.ax      = ax_a_ff;
      lane_in.x2      = {2'b00, sq} << SQ_SHIFT;
      lane_in.s       = $signed(START);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff    <= 1'b0;
         lane_ff.valid <= 1'b0;
      end else if (en) begin
         valid_a_ff    <= valid_a_in;
         lane_ff       <= lane_in;
      end
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      if (en) begin
         xneg_a_ff <= xneg_a_in;
         ax_a_ff   <= ax_a_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

FILE: hdl/tse_cell.sv
// ----------------------------------------------------------------------------
// tse_cell
// One Horner step of the chain: s' = COEF - round(x^2 * s). The 64x64 product
// is built from four 32x32 partial products over four register stages.
// ----------------------------------------------------------------------------
module tse_cell #(
   parameter logic [63:0] COEF = 64'd0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  tse_pkg::lane_type lane_in,
   output tse_pkg::lane_type lane_out
);

   localparam logic [127:0] HALF = 128'd1 << (tse_pkg::WORK_FRAC - 1);
   localparam logic [67:0]  SAT  = 68'd1 << 62;

   logic [63:0]       mag;
   logic [63:0]       p00_ff, p01_ff, p10_ff, p11_ff;
   logic [63:0]       p00_in, p01_in, p10_in, p11_in;
   logic              neg1_ff, neg2_ff, neg3_ff;
   logic [127:0]      acc_ff, acc_in;
   logic [127:0]      rnd;
   logic [67:0]       hi;
   logic [62:0]       prod_ff, prod_in;
   logic [63:0]       s_sum;
   tse_pkg::lane_type lane1_ff, lane2_ff, lane3_ff, lane4_ff, lane4_in;

   // Stage 1: split the operands and form the partial products
   always_comb begin
      mag    = lane_in.s[63] ? (64'd0 - $unsigned(lane_in.s)) : $unsigned(lane_in.s);
      p00_in = 64'(lane_in.x2[31:0])  * 64'(mag[31:0]);
      p01_in = 64'(lane_in.x2[31:0])  * 64'(mag[63:32]);
      p10_in = 64'(lane_in.x2[63:32]) * 64'(mag[31:0]);
      p11_in = 64'(lane_in.x2[63:32]) * 64'(mag[63:32]);
   end

   // Stage 2: gather the partial products
   assign acc_in = {p11_ff, p00_ff} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0};

   // Stage 3: round half up to Q60 and limit to 2^62
   always_comb begin
      rnd = acc_ff + HALF;
      hi  = rnd[127:tse_pkg::WORK_FRAC];
      if (hi > SAT) begin
         prod_in = SAT[62:0];
      end else begin
         prod_in = hi[62:0];
      end
   end

   // Stage 4: subtract the signed product from the coefficient
   always_comb begin
      s_sum      = neg3_ff ? (COEF + {1'b0, prod_ff}) : (COEF - {1'b0, prod_ff});
      lane4_in   = lane3_ff;
      lane4_in.s = $signed(s_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane1_ff.valid <= 1'b0;
         lane2_ff.valid <= 1'b0;
         lane3_ff.valid <= 1'b0;
         lane4_ff.valid <= 1'b0;
      end else if (en) begin
         lane1_ff <= lane_in;
         lane2_ff <= lane1_ff;
         lane3_ff <= lane2_ff;
         lane4_ff <= lane4_in;
      end
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         neg1_ff <= lane_in.s[63];
         acc_ff  <= acc_in;
         neg2_ff <= neg1_ff;
         prod_ff <= prod_in;
         neg3_ff <= neg2_ff;
      end
   end

   assign lane_out = lane4_ff;

endmodule

FILE: hdl/tse_tail.sv
// ----------------------------------------------------------------------------
// tse_tail
// End of the chain: multiplies |x| by the accumulator, rounds to the output
// format, saturates to one, applies the sign and holds the result register.
// ----------------------------------------------------------------------------
module tse_tail #(
   parameter int unsigned FRAC_BITS = 28
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               en_out,
   input  tse_pkg::lane_type                  lane_in,
   output logic                               last_valid,
   output logic                               rsp_valid,
   output logic signed [tse_pkg::SINE_W-1:0]  rsp_sine_value
);

   localparam logic [95:0] HALF = 96'd1 << (tse_pkg::WORK_FRAC - 1);
   localparam logic [35:0] ONE  = 36'd1 << FRAC_BITS;

   logic [63:0]                 mag;
   logic [62:0]                 q0_ff, q0_in, q1_ff, q1_in;
   logic                        v1_ff, v2_ff, rneg1_ff, rneg2_ff, rneg1_in;
   logic [95:0]                 sum_ff, sum_in;
   logic [35:0]                 hi, ym, res;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tse_pkg::SINE_W-1:0]  sine_ff, sine_in;

   // Stage 1: partial products of |x| and |s|
   always_comb begin
      mag      = lane_in.s[63] ? (64'd0 - $unsigned(lane_in.s)) : $unsigned(lane_in.s);
      q0_in    = 63'(lane_in.ax) * 63'(mag[31:0]);
      q1_in    = 63'(lane_in.ax) * 63'(mag[63:32]);
      rneg1_in = lane_in.xneg ^ lane_in.s[63];
   end

   // Stage 2: gather and add the rounding half
   assign sum_in = {33'd0, q0_ff} + {1'b0, q1_ff, 32'd0} + HALF;

   // Output stage: shift down, saturate to one, restore the sign
   always_comb begin
      hi           = sum_ff[95:tse_pkg::WORK_FRAC];
      ym           = (hi > ONE) ? ONE : hi;
      res          = rneg2_ff ? (36'd0 - ym) : ym;
      sine_in      = res[tse_pkg::SINE_W-1:0];
      rsp_valid_in = v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else if (en) begin
         v1_ff        <= lane_in.valid;
         v2_ff        <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      if (en) begin
         q0_ff    <= q0_in;
         q1_ff    <= q1_in;
         rneg1_ff <= rneg1_in;
         sum_ff   <= sum_in;
         rneg2_ff <= rneg1_ff;
      end
      if (en_out) begin
         sine_ff  <= sine_in;
      end
   end

   assign last_valid     = v2_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sine_value = $signed(sine_ff);

endmodule

FILE: hdl/taylor_sine_evaluator.sv
// ----------------------------------------------------------------------------
// taylor_sine_evaluator: sine of a Q3.FRAC_BITS angle by a TERMS-term series
// Pipeline: two entry stages, four per Horner cell (one 64x64 product split
//   into 32x32 parts), three at the end. Throughput one request per cycle
//   unless a full output register is not taken and stalls the chain.
// Synchronous active-high reset clears all valid bits; no other state.
// ----------------------------------------------------------------------------
module taylor_sine_evaluator #(
   parameter int unsigned TERMS     = 10,
   parameter int unsigned FRAC_BITS = 28
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [tse_pkg::ANGLE_W-1:0] req_angle,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tse_pkg::SINE_W-1:0]  rsp_sine_value
);

   localparam logic [63:0] START = tse_pkg::coef(TERMS - 1);

   logic              en;
   logic              en_out;
   logic              last_valid;
   tse_pkg::lane_type chain [TERMS];

   // Advance the output register when it is free or being taken; advance the
   // chain as well when its last stage holds a bubble
   assign en_out    = !rsp_valid || rsp_ready;
   assign en        = en_out || !last_valid;
   assign req_ready = en;

   tse_front #(
      .FRAC_BITS (FRAC_BITS),
      .START     (START)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req_angle (req_angle),
      .lane_out  (chain[0])
   );

   // Horner cells, highest coefficient first
   for (genvar i = 0; i < TERMS - 1; i++) begin : g_cell
      tse_cell #(
         .COEF (tse_pkg::coef(TERMS - 2 - i))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .lane_in  (chain[i]),
         .lane_out (chain[i+1])
      );
   end

   tse_tail #(
      .FRAC_BITS (FRAC_BITS)
   ) u_tail (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .en_out         (en_out),
      .lane_in        (chain[TERMS-1]),
      .last_valid     (last_valid),
      .rsp_valid      (rsp_valid),
      .rsp_sine_value (rsp_sine_value)
   );

endmodule

FILE: hdl/tse_checker.sv
// ----------------------------------------------------------------------------
// tse_checker
// Port-level checks on the sine evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module tse_checker #(
   parameter int unsigned FRAC_BITS = 28
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic signed [tse_pkg::ANGLE_W-1:0] req_angle,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [tse_pkg::SINE_W-1:0]  rsp_sine_value
);

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   logic signed [31:0] sine_ext;

   assign sine_ext = 32'(rsp_sine_value);

   // Reset drops any pending result
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A waiting request keeps its angle until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_angle))
      else $error("waiting request changed");

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sine_value))
      else $error("stalled result changed");

   // An empty output register never blocks a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   // The result never goes beyond plus or minus one
   a_sine_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (sine_ext <= ONE) && (sine_ext >= -ONE))
      else $error("sine beyond one");

endmodule

bind taylor_sine_evaluator tse_checker #(.FRAC_BITS(FRAC_BITS)) u_tse_checker (.*);
